>>> rtl/dprc_pkg.sv
// Shared types and constants of the domain packet rule classifier.
// Depends on nothing; dprc_cell and the core import it.
`default_nettype none
package dprc_pkg;

    localparam int DOMAIN_SLOTS = 64;
    localparam int RULE_SLOTS   = 256;
    localparam int CHUNK        = 16;
    localparam int NCHUNK       = RULE_SLOTS / CHUNK;
    localparam int DIDX_W       = $clog2(DOMAIN_SLOTS);
    localparam int DCNT_W       = $clog2(DOMAIN_SLOTS + 1);
    localparam int RIDX_W       = $clog2(RULE_SLOTS);
    localparam int RCNT_W       = $clog2(RULE_SLOTS + 1);
    localparam int CH_W         = $clog2(NCHUNK);
    localparam int CK_W         = $clog2(CHUNK);

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_ADD      = 2'd1;
    localparam logic [1:0] ACT_EVAL     = 2'd2;

    localparam logic [1:0] VERD_ALLOW = 2'd0;
    localparam logic [1:0] VERD_DENY  = 2'd1;
    localparam logic [1:0] VERD_LOG   = 2'd2;
    localparam logic [1:0] VERD_DROP  = 2'd3;

    localparam logic [1:0] DIR_BOTH = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  domain_num;
        logic        isolated;
        logic [7:0]  protocol;
        logic [1:0]  direction;
        logic [1:0]  rule_verdict;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } item_t;

    typedef struct packed {
        logic [8:0]  new_id;
        logic [1:0]  verdict;
        logic [8:0]  matched_rule;
        logic [31:0] blocked_count;
        logic [31:0] allowed_count;
        logic [31:0] rule_hits;
        logic [63:0] eval_total;
    } result_t;

    typedef struct packed {
        logic [6:0]  dom;
        logic [7:0]  protocol;
        logic [1:0]  direction;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
    } rule_key_t;

    typedef struct packed {
        logic we;
        logic cmp_en;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/dprc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module dprc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/dprc_cell.sv
// One rule cell: holds a rule and registers whether a packet key matches it.
// Depends on dprc_pkg.
`default_nettype none
module dprc_cell (
    input  wire logic               clk,
    input  wire dprc_pkg::cell_ctl_t ctl,
    input  wire logic               sel,
    input  wire dprc_pkg::rule_key_t wr_rule,
    input  wire dprc_pkg::rule_key_t key,
    output logic                    match
);
    import dprc_pkg::*;

    rule_key_t rule_reg;
    logic      match_reg;
    logic      hit;

    always_comb
    begin
        hit = (rule_reg.dom == key.dom)
            && (rule_reg.protocol == 8'd0 || rule_reg.protocol == key.protocol)
            && (rule_reg.direction == DIR_BOTH || rule_reg.direction == key.direction)
            && (rule_reg.src == 32'd0 || rule_reg.src == key.src)
            && (rule_reg.dst == 32'd0 || rule_reg.dst == key.dst)
            && (rule_reg.sport == 16'd0 || rule_reg.sport == key.sport)
            && (rule_reg.dport == 16'd0 || rule_reg.dport == key.dport);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we && sel)
        begin
            rule_reg <= wr_rule;
        end
        if (ctl.cmp_en)
        begin
            match_reg <= hit;
        end
    end

    assign match = match_reg;
endmodule
`default_nettype wire

>>> rtl/domain_packet_rule_classifier_core.sv
// Top level of the domain packet rule classifier: control, rule cells, tables.
// Depends on dprc_pkg, dprc_cell and dprc_ram.
//
// Usage: drive item and raise start; the beat is taken on a clock edge where
// start is high and busy is low. Each item gives exactly one result beat on
// result, marked by done for one cycle; the receiver cannot stall it.
// Register domain, add rule and unused action codes: result in the cycle after
// the beat, busy stays low, so such items may follow back to back.
// Evaluate on an invalid domain: result in the cycle after the beat, no busy.
// Evaluate on a valid domain: all rule cells compare in parallel and register
// their match bits, then the registered match vector is scanned 16 rules per
// cycle for the first match; a hit then passes through a table read state and
// an update state. busy is high throughout, and a new item is taken the cycle
// done rises.
// Reset clears domain count, rule count and evaluation count; tables hold
// no valid bits and are only read below those counts.
`default_nettype none
module domain_packet_rule_classifier_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire dprc_pkg::item_t item,
    output logic                 done,
    output dprc_pkg::result_t    result
);
    import dprc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EV_RD,
        S_SCAN,
        S_HIT_RD,
        S_HIT_UP
    } state_t;

    state_t              state_reg, state_next;
    item_t               req_reg, req_next;
    logic [DCNT_W-1:0]   domain_total_reg, domain_total_next;
    logic [RCNT_W-1:0]   rule_total_reg, rule_total_next;
    logic [63:0]         evaluations_reg, evaluations_next;
    logic [CH_W-1:0]     chunk_reg, chunk_next;
    logic [RIDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    cell_ctl_t           cell_ctl;
    rule_key_t           wr_rule, key;
    logic [RULE_SLOTS-1:0] match_vec;

    logic                dom_we;
    logic [DIDX_W-1:0]   dom_waddr, dom_raddr;
    logic                iso_wdata, iso_rd;
    logic [31:0]         blk_wdata, alw_wdata, blk_rd, alw_rd;
    logic                verd_we, hit_we;
    logic [RIDX_W-1:0]   rule_waddr, hit_waddr;
    logic [31:0]         hit_wdata, hit_rd;
    logic [1:0]          verd_rd;
    logic                iso_we;

    logic                dom_ok;
    logic [CHUNK-1:0]    chunk_bits;
    logic                found;
    logic [CK_W-1:0]     found_k;
    logic [RIDX_W-1:0]   base_idx;

    assign wr_rule = '{dom: item.domain_num, protocol: item.protocol,
                       direction: item.direction, src: item.source_address,
                       dst: item.dest_address, sport: item.source_port,
                       dport: item.dest_port};
    assign key = '{dom: req_reg.domain_num, protocol: req_reg.protocol,
                   direction: req_reg.direction, src: req_reg.source_address,
                   dst: req_reg.dest_address, sport: req_reg.source_port,
                   dport: req_reg.dest_port};

    genvar gi;
    generate
        for (gi = 0; gi < RULE_SLOTS; gi++)
        begin : g_cell
            dprc_cell u_cell (
                .clk     (clk),
                .ctl     (cell_ctl),
                .sel     (rule_waddr == RIDX_W'(gi)),
                .wr_rule (wr_rule),
                .key     (key),
                .match   (match_vec[gi])
            );
        end
    endgenerate

    assign dom_raddr = DIDX_W'(req_reg.domain_num - 7'd1);

    dprc_ram #(.WIDTH(1), .DEPTH(DOMAIN_SLOTS)) u_iso_ram (
        .clk(clk), .we(iso_we), .waddr(dom_waddr), .wdata(iso_wdata),
        .raddr(dom_raddr), .rdata(iso_rd)
    );
    dprc_ram #(.WIDTH(32), .DEPTH(DOMAIN_SLOTS)) u_blk_ram (
        .clk(clk), .we(dom_we), .waddr(dom_waddr), .wdata(blk_wdata),
        .raddr(dom_raddr), .rdata(blk_rd)
    );
    dprc_ram #(.WIDTH(32), .DEPTH(DOMAIN_SLOTS)) u_alw_ram (
        .clk(clk), .we(dom_we), .waddr(dom_waddr), .wdata(alw_wdata),
        .raddr(dom_raddr), .rdata(alw_rd)
    );
    dprc_ram #(.WIDTH(2), .DEPTH(RULE_SLOTS)) u_verd_ram (
        .clk(clk), .we(verd_we), .waddr(rule_waddr), .wdata(item.rule_verdict),
        .raddr(hit_idx_reg), .rdata(verd_rd)
    );
    dprc_ram #(.WIDTH(32), .DEPTH(RULE_SLOTS)) u_hit_ram (
        .clk(clk), .we(hit_we), .waddr(hit_waddr), .wdata(hit_wdata),
        .raddr(hit_idx_reg), .rdata(hit_rd)
    );

    assign dom_ok = (item.domain_num != 7'd0)
                    && ({1'b0, item.domain_num} <= 8'(domain_total_reg));
    assign rule_waddr = RIDX_W'(rule_total_reg);

    always_comb
    begin
        chunk_bits = match_vec[chunk_reg * CHUNK +: CHUNK];
        found      = 1'b0;
        found_k    = '0;
        base_idx   = '0;
        for (int k = CHUNK - 1; k >= 0; k--)
        begin
            base_idx = {chunk_reg, CK_W'(k)};
            if (chunk_bits[k] && (RCNT_W'(base_idx) < rule_total_reg))
            begin
                found   = 1'b1;
                found_k = CK_W'(k);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        domain_total_next = domain_total_reg;
        rule_total_next   = rule_total_reg;
        evaluations_next  = evaluations_reg;
        chunk_next        = chunk_reg;
        hit_idx_next      = hit_idx_reg;
        done_next         = 1'b0;
        res_next          = res_reg;
        cell_ctl          = '{we: 1'b0, cmp_en: 1'b0};
        iso_we            = 1'b0;
        dom_we            = 1'b0;
        dom_waddr         = dom_raddr;
        iso_wdata         = item.isolated;
        blk_wdata         = 32'd0;
        alw_wdata         = 32'd0;
        verd_we           = 1'b0;
        hit_we            = 1'b0;
        hit_waddr         = rule_waddr;
        hit_wdata         = 32'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = item;
                    done_next = 1'b1;
                    res_next  = '0;
                    res_next.eval_total = evaluations_reg;
                    case (item.action)
                        ACT_REGISTER:
                        begin
                            if (domain_total_reg < DCNT_W'(DOMAIN_SLOTS))
                            begin
                                iso_we            = 1'b1;
                                dom_we            = 1'b1;
                                dom_waddr         = DIDX_W'(domain_total_reg);
                                domain_total_next = domain_total_reg + 1'b1;
                                res_next.new_id   = 9'(domain_total_reg) + 9'd1;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (dom_ok && rule_total_reg < RCNT_W'(RULE_SLOTS))
                            begin
                                cell_ctl.we     = 1'b1;
                                verd_we         = 1'b1;
                                hit_we          = 1'b1;
                                rule_total_next = rule_total_reg + 1'b1;
                                res_next.new_id = 9'(rule_total_reg) + 9'd1;
                            end
                        end
                        ACT_EVAL:
                        begin
                            evaluations_next    = evaluations_reg + 64'd1;
                            res_next.eval_total = evaluations_reg + 64'd1;
                            res_next.verdict    = VERD_DENY;
                            if (dom_ok)
                            begin
                                done_next  = 1'b0;
                                state_next = S_EV_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EV_RD:
            begin
                cell_ctl.cmp_en = 1'b1;
                chunk_next      = '0;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                if (iso_rd)
                begin
                    dom_we                 = 1'b1;
                    blk_wdata              = blk_rd + 32'd1;
                    alw_wdata              = alw_rd;
                    res_next.verdict       = VERD_DROP;
                    res_next.blocked_count = blk_rd + 32'd1;
                    res_next.allowed_count = alw_rd;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
                else if (found)
                begin
                    hit_idx_next = {chunk_reg, found_k};
                    state_next   = S_HIT_RD;
                end
                else if (chunk_reg == CH_W'(NCHUNK - 1))
                begin
                    dom_we                 = 1'b1;
                    blk_wdata              = blk_rd + 32'd1;
                    alw_wdata              = alw_rd;
                    res_next.verdict       = VERD_DENY;
                    res_next.blocked_count = blk_rd + 32'd1;
                    res_next.allowed_count = alw_rd;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            S_HIT_RD:
            begin
                state_next = S_HIT_UP;
            end
            S_HIT_UP:
            begin
                hit_we    = 1'b1;
                hit_waddr = hit_idx_reg;
                hit_wdata = hit_rd + 32'd1;
                dom_we    = 1'b1;
                if (verd_rd == VERD_ALLOW || verd_rd == VERD_LOG)
                begin
                    blk_wdata = blk_rd;
                    alw_wdata = alw_rd + 32'd1;
                end
                else
                begin
                    blk_wdata = blk_rd + 32'd1;
                    alw_wdata = alw_rd;
                end
                res_next.verdict       = verd_rd;
                res_next.matched_rule  = 9'(hit_idx_reg) + 9'd1;
                res_next.rule_hits     = hit_rd + 32'd1;
                res_next.blocked_count = blk_wdata;
                res_next.allowed_count = alw_wdata;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            domain_total_reg <= '0;
            rule_total_reg   <= '0;
            evaluations_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            domain_total_reg <= domain_total_next;
            rule_total_reg   <= rule_total_next;
            evaluations_reg  <= evaluations_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        chunk_reg   <= chunk_next;
        hit_idx_reg <= hit_idx_next;
        res_reg     <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy) || $past(busy))
        else $error("result beat without an item in work");
    a_domain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        domain_total_reg <= DCNT_W'(DOMAIN_SLOTS))
        else $error("domain count past table size");
    a_rule_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_total_reg <= RCNT_W'(RULE_SLOTS))
        else $error("rule count past table size");
    a_match_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.matched_rule != 9'd0 |-> result.rule_hits != 32'd0
            || $past(state_reg) == S_HIT_UP)
        else $error("matched rule without hit update");
`endif
endmodule
`default_nettype wire
